[src/min_max_contiguous_partition_top_macros.svh]
// assertion helpers, sampled on i_clk and held off while i_rst_n is low
`ifndef MIN_MAX_CONTIGUOUS_PARTITION_TOP_MACROS_SVH
`define MIN_MAX_CONTIGUOUS_PARTITION_TOP_MACROS_SVH

// same-cycle implication
`define MMCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MMCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/mmcp_pkg.sv]
package mmcp_pkg;

    localparam int PAGE_W   = 16;
    localparam int GROUP_W  = 11;
    localparam int STATUS_W = 2;
    localparam int RESULT_W = 26;

    localparam logic [GROUP_W-1:0] GROUP_RESET = GROUP_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_FEW = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_STAT_OVF,
        OP_STAT_FEW,
        OP_INIT,
        OP_MID,
        OP_PRIME,
        OP_WALK,
        OP_EVAL,
        OP_ANSWER,
        OP_EMIT
    } t_uop;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_LAST,
        C_OVF,
        C_FEW,
        C_LOW_GT_HIGH,
        C_WALK_MORE,
        C_NOT_STOP,
        C_OUT_BUSY
    } t_cond;

    typedef logic [3:0] t_upc;

    localparam int UROM_DEPTH = 16;

    localparam t_upc U_IDLE    = 4'd0;
    localparam t_upc U_CHK_OVF = 4'd1;
    localparam t_upc U_CHK_FEW = 4'd2;
    localparam t_upc U_INIT    = 4'd3;
    localparam t_upc U_LOOP    = 4'd4;
    localparam t_upc U_PRIME   = 4'd5;
    localparam t_upc U_WALK    = 4'd6;
    localparam t_upc U_EVAL    = 4'd7;
    localparam t_upc U_DONE    = 4'd8;
    localparam t_upc U_OUT     = 4'd9;
    localparam t_upc U_RET     = 4'd10;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // next step is target when the condition holds, else the following step
    localparam t_uword UROM [UROM_DEPTH] = '{
        '{OP_NOP,      C_NO_LAST,     U_IDLE},   // idle: take words
        '{OP_STAT_OVF, C_OVF,         U_OUT},    // store overflowed
        '{OP_STAT_FEW, C_FEW,         U_OUT},    // too few books
        '{OP_INIT,     C_NEVER,       U_IDLE},   // open search window
        '{OP_MID,      C_LOW_GT_HIGH, U_DONE},   // pick probe bound
        '{OP_PRIME,    C_NEVER,       U_IDLE},   // first store read
        '{OP_WALK,     C_WALK_MORE,   U_WALK},   // greedy walk
        '{OP_EVAL,     C_NOT_STOP,    U_LOOP},   // narrow window
        '{OP_ANSWER,   C_NEVER,       U_IDLE},   // take best bound
        '{OP_EMIT,     C_OUT_BUSY,    U_OUT},    // hand off result
        '{OP_NOP,      C_ALWAYS,      U_IDLE},   // back to idle
        '{OP_NOP,      C_ALWAYS,      U_IDLE},
        '{OP_NOP,      C_ALWAYS,      U_IDLE},
        '{OP_NOP,      C_ALWAYS,      U_IDLE},
        '{OP_NOP,      C_ALWAYS,      U_IDLE},
        '{OP_NOP,      C_ALWAYS,      U_IDLE}
    };

endpackage

[src/mmcp_if.sv]
interface mmcp_book_if import mmcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_count;
    logic              last_book;

    modport source (output valid, output page_count, output last_book, input ready);
    modport sink   (input valid, input page_count, input last_book, output ready);
endinterface

interface mmcp_result_if import mmcp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RESULT_W-1:0] min_max_pages;

    modport source (output valid, output status, output min_max_pages, input ready);
    modport sink   (input valid, input status, input min_max_pages, output ready);
endinterface

interface mmcp_cfg_if import mmcp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [GROUP_W-1:0] group_count;

    modport source (output valid, output group_count, input ready);
    modport sink   (input valid, input group_count, output ready);
endinterface

[src/mmcp_ram.sv]
module mmcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/min_max_contiguous_partition_top.sv]
// Linear partition by binary search on the answer. Books arrive on i_book as page
// counts, one word per cycle while i_book is ready (idle step only), and are written
// into an internal store while a running page total is kept. The word flagged
// last_book starts a search for the smallest bound that lets the stored books, in
// order, split into at most group_count contiguous groups; exactly one result word
// follows: status 0 with the bound, status 1 (group_count is zero or fewer books than
// groups) or status 2 (more books arrived than MAX_BOOKS; extra books are dropped),
// the bound reading 0 for a nonzero status. After the result the set is cleared.
// After the last book i_book stays not ready until the sequencer is back in idle.
// The search makes at most about log2(total pages + 1) + 1 probes; each probe costs
// a window step, a read priming step, N walk steps (N books stored) through the
// single read port of the book RAM (one book per cycle) and an evaluation step;
// status 1 and 2 skip the search. The hand-off step waits while an earlier result
// still sits unaccepted in the output register. A result waiting in the output
// register does not hold off the next set's books until the next search wants to
// hand over. group_count is written on i_cfg (always ready) and must only change
// while no set is loading or searching.
`include "min_max_contiguous_partition_top_macros.svh"

module min_max_contiguous_partition_top import mmcp_pkg::*; #(
    parameter int MAX_BOOKS = 1024,
    parameter int PAGE_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mmcp_book_if.sink     i_book,
    mmcp_cfg_if.sink      i_cfg,
    mmcp_result_if.source o_result
);

    localparam int CNT_W  = $clog2(MAX_BOOKS + 1);
    localparam int ADDR_W = (MAX_BOOKS > 1) ? $clog2(MAX_BOOKS) : 1;
    localparam int SUM_W  = CNT_W + PAGE_BITS;
    localparam int CMP_W  = (CNT_W > GROUP_W) ? CNT_W : GROUP_W;

    // sequencer
    t_upc   r_upc, n_upc;
    t_uword w_uw;
    logic   w_cond;

    // set loading
    logic [CNT_W-1:0]   r_books_loaded, n_books_loaded;
    logic [SUM_W-1:0]   r_page_total, n_page_total;
    logic               r_overflowed, n_overflowed;
    logic [GROUP_W-1:0] r_group_count;

    // search datapath
    logic [SUM_W-1:0] r_low, n_low;
    logic [SUM_W-1:0] r_high, n_high;
    logic [SUM_W-1:0] r_best, n_best;
    logic [SUM_W-1:0] r_mid, n_mid;
    logic [SUM_W-1:0] r_probe_sum, n_probe_sum;
    logic [CNT_W-1:0] r_groups, n_groups;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_fail, n_fail;
    t_status          r_status, n_status;
    logic [SUM_W-1:0] r_answer, n_answer;

    // output register
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [RESULT_W-1:0] r_out_pages, n_out_pages;

    logic                 w_fire;
    logic                 w_store_we;
    logic [PAGE_BITS-1:0] w_page;
    logic [PAGE_BITS-1:0] w_rd;
    logic [SUM_W-1:0]     w_book;
    logic [SUM_W-1:0]     w_try;
    logic [SUM_W:0]       w_mid_sum;
    logic                 w_fits;
    logic                 w_few;
    logic                 w_out_busy;

    assign w_uw   = UROM[r_upc];
    assign w_fire = i_book.valid && i_book.ready;
    assign w_page = PAGE_BITS'(i_book.page_count);

    assign w_store_we = w_fire && (r_books_loaded < CNT_W'(MAX_BOOKS));

    mmcp_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_BOOKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_books_loaded[ADDR_W-1:0]),
        .i_wdata (w_page),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_rd)
    );

    assign w_book    = SUM_W'(w_rd);
    assign w_try     = r_probe_sum + w_book;
    assign w_mid_sum = (SUM_W + 1)'(r_low) + (SUM_W + 1)'(r_high);
    assign w_fits    = !r_fail && (CMP_W'(r_groups) <= CMP_W'(r_group_count));
    assign w_few     = (r_group_count == '0)
                    || (CMP_W'(r_books_loaded) < CMP_W'(r_group_count));
    assign w_out_busy = r_out_valid && !o_result.ready;

    // handshake ports
    assign i_book.ready           = (r_upc == U_IDLE);
    assign i_cfg.ready            = 1'b1;
    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.min_max_pages = r_out_pages;

    // jump condition select
    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:       w_cond = 1'b0;
            C_ALWAYS:      w_cond = 1'b1;
            C_NO_LAST:     w_cond = !(w_fire && i_book.last_book);
            C_OVF:         w_cond = r_overflowed;
            C_FEW:         w_cond = w_few;
            C_LOW_GT_HIGH: w_cond = (r_low > r_high);
            C_WALK_MORE:   w_cond = (r_idx < r_books_loaded);
            C_NOT_STOP:    w_cond = !(w_fits && (r_mid == '0));
            C_OUT_BUSY:    w_cond = w_out_busy;
            default:       w_cond = 1'b1;
        endcase
    end

    // step counter
    always_comb begin
        n_upc = w_cond ? w_uw.target : t_upc'(r_upc + 4'd1);
    end

    // datapath driven by the control word
    always_comb begin
        n_books_loaded = r_books_loaded;
        n_page_total   = r_page_total;
        n_overflowed   = r_overflowed;
        n_low          = r_low;
        n_high         = r_high;
        n_best         = r_best;
        n_mid          = r_mid;
        n_probe_sum    = r_probe_sum;
        n_groups       = r_groups;
        n_idx          = r_idx;
        n_fail         = r_fail;
        n_status       = r_status;
        n_answer       = r_answer;
        n_out_valid    = r_out_valid && !o_result.ready;
        n_out_status   = r_out_status;
        n_out_pages    = r_out_pages;

        // book intake, a full store drops the word and flags it
        if (w_fire) begin
            if (w_store_we) begin
                n_books_loaded = r_books_loaded + CNT_W'(1);
                n_page_total   = r_page_total + SUM_W'(w_page);
            end else begin
                n_overflowed = 1'b1;
            end
        end

        unique case (w_uw.op)
            OP_NOP: begin
            end
            OP_STAT_OVF: begin
                n_status = ST_OVF;
                n_answer = '0;
            end
            OP_STAT_FEW: begin
                n_status = ST_FEW;
                n_answer = '0;
            end
            OP_INIT: begin
                n_status = ST_OK;
                n_low    = '0;
                n_high   = r_page_total;
                n_best   = r_page_total;
            end
            OP_MID: begin
                n_mid       = w_mid_sum[SUM_W:1];
                n_idx       = '0;
                n_probe_sum = '0;
                n_groups    = CNT_W'(1);
                n_fail      = 1'b0;
            end
            OP_PRIME: begin
                n_idx = r_idx + CNT_W'(1);
            end
            OP_WALK: begin
                n_idx = r_idx + CNT_W'(1);
                if (w_book > r_mid) begin
                    n_fail = 1'b1;
                end else if (w_try <= r_mid) begin
                    n_probe_sum = w_try;
                end else begin
                    n_probe_sum = w_book;
                    n_groups    = r_groups + CNT_W'(1);
                end
            end
            OP_EVAL: begin
                if (w_fits) begin
                    n_best = r_mid;
                    if (r_mid != '0) begin
                        n_high = r_mid - SUM_W'(1);
                    end
                end else begin
                    n_low = r_mid + SUM_W'(1);
                end
            end
            OP_ANSWER: begin
                n_answer = r_best;
            end
            OP_EMIT: begin
                if (!w_out_busy) begin
                    n_out_valid    = 1'b1;
                    n_out_status   = r_status;
                    n_out_pages    = RESULT_W'(r_answer);
                    n_books_loaded = '0;
                    n_page_total   = '0;
                    n_overflowed   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc          <= U_IDLE;
            r_books_loaded <= '0;
            r_page_total   <= '0;
            r_overflowed   <= 1'b0;
            r_group_count  <= GROUP_RESET;
            r_low          <= '0;
            r_high         <= '0;
            r_best         <= '0;
            r_probe_sum    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_upc          <= n_upc;
            r_books_loaded <= n_books_loaded;
            r_page_total   <= n_page_total;
            r_overflowed   <= n_overflowed;
            r_low          <= n_low;
            r_high         <= n_high;
            r_best         <= n_best;
            r_probe_sum    <= n_probe_sum;
            r_out_valid    <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_group_count <= i_cfg.group_count;
            end
        end
    end

    // payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_mid        <= n_mid;
        r_groups     <= n_groups;
        r_idx        <= n_idx;
        r_fail       <= n_fail;
        r_status     <= n_status;
        r_answer     <= n_answer;
        r_out_status <= n_out_status;
        r_out_pages  <= n_out_pages;
    end

    // a result word only appears from the hand-off step
    `MMCP_ASSERT_NOW(a_out_from_emit, $rose(r_out_valid), $past(r_upc) == U_OUT, "result without hand-off")

    // handing off a result leaves an empty set behind
    `MMCP_ASSERT_NEXT(a_set_cleared, (r_upc == U_OUT) && !w_out_busy, (r_books_loaded == '0) && !r_overflowed, "set not cleared")

    // the walk never reads past the loaded books
    `MMCP_ASSERT_NOW(a_walk_in_range, r_upc == U_WALK, (r_idx != '0) && (r_idx <= r_books_loaded), "walk index out of range")

    // the best bound never exceeds the page total while searching
    `MMCP_ASSERT_NOW(a_best_bounded, r_upc == U_EVAL, r_best <= r_page_total, "best bound above total")

endmodule

[tb/tb_min_max_contiguous_partition_top.sv]
module tb_min_max_contiguous_partition_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mmcp_pkg::*;

    localparam int SHELF_DEPTH   = 1024;
    localparam int CLOCK_LIMIT   = 2_000_000;
    // cycles allowed after the last result for the sequencer to return to idle
    localparam int SETTLE_CYCLES = 16;
    localparam logic [GROUP_W-1:0] GROUPS_ALL_ONES = '1;
    localparam logic [PAGE_W-1:0]  PAGES_ALL_ONES  = '1;

    // how page counts are drawn for a set
    typedef enum int {
        PAGES_WIDE,
        PAGES_NARROW,
        PAGES_EDGE
    } t_page_mix;

    // one result word as the block should send it
    typedef struct {
        t_status             status;
        logic [RESULT_W-1:0] pages;
    } t_partition_result;

    logic clk;
    logic rst_n;

    mmcp_book_if   book_bus ();
    mmcp_cfg_if    cfg_bus ();
    mmcp_result_if result_bus ();

    min_max_contiguous_partition_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_book   (book_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    // shadow of the block: books of the open set, running total and group count
    logic [PAGE_W-1:0]  shelf [SHELF_DEPTH];
    int unsigned        shelf_count;
    logic [26:0]        shelf_total;
    bit                 shelf_overflow;
    logic [GROUP_W-1:0] groups_cfg;

    // partitions predicted but not yet seen on the result port
    t_partition_result pending_partitions [$];

    int book_idle_pct;
    int result_stall_pct;
    int errors;
    int books_sent;
    int sets_sent;
    int results_seen;
    int group_writes;
    int status_tally [3];
    int cycle_count;

    // clock and sink-side back pressure
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk) begin
        result_bus.ready <= ($urandom_range(99) >= result_stall_pct);
    end

    // greedy walk: do the shelved books fit in groups_cfg groups under bound
    function automatic bit bound_fits(input longint bound);
        int     groups;
        longint run;
        groups = 1;
        run    = 0;
        for (int i = 0; i < shelf_count; i++) begin
            if (shelf[i] > bound) return 1'b0;
            if (run + shelf[i] <= bound) begin
                run += shelf[i];
            end else begin
                run = shelf[i];
                groups++;
            end
        end
        return groups <= groups_cfg;
    endfunction

    // shelve one accepted book word; the last book of a set yields a partition
    function automatic void shelve_book(input logic [PAGE_W-1:0] pages, input bit last);
        t_partition_result part;
        longint            lo;
        longint            hi;
        longint            mid;
        longint            best;
        if (shelf_count < SHELF_DEPTH) begin
            shelf[shelf_count] = pages;
            shelf_count++;
            shelf_total += pages;
        end else begin
            shelf_overflow = 1'b1;
        end
        if (!last) return;
        part.pages = '0;
        if (shelf_overflow) begin
            part.status = ST_OVF;
        end else if (groups_cfg == 0 || shelf_count < groups_cfg) begin
            part.status = ST_FEW;
        end else begin
            // binary search over 0 to the set total
            part.status = ST_OK;
            lo   = 0;
            hi   = shelf_total;
            best = shelf_total;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (bound_fits(mid)) begin
                    best = mid;
                    if (mid == 0) break;
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            part.pages = best[RESULT_W-1:0];
        end
        pending_partitions.push_back(part);
        status_tally[part.status]++;
        sets_sent++;
        shelf_count    = 0;
        shelf_total    = '0;
        shelf_overflow = 1'b0;
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge clk) begin
        t_partition_result want;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            results_seen++;
            if (pending_partitions.size() == 0) begin
                $display("%0t: unexpected result word, status %0d pages %0d", $time,
                         result_bus.status, result_bus.min_max_pages);
                errors++;
            end else begin
                want = pending_partitions.pop_front();
                if (result_bus.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, result_bus.status);
                    errors++;
                end
                if (result_bus.min_max_pages !== want.pages) begin
                    $display("%0t: min_max_pages expected %0d actual %0d", $time,
                             want.pages, result_bus.min_max_pages);
                    errors++;
                end
            end
        end
    end

    // watchdog on a hung block
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CLOCK_LIMIT) begin
            $display("FAIL min_max_contiguous_partition_top");
            $finish;
        end
    end

    function automatic logic [PAGE_W-1:0] random_pages(input t_page_mix mix);
        case (mix)
            PAGES_WIDE:   return PAGE_W'($urandom_range(65535));
            PAGES_NARROW: return PAGE_W'($urandom_range(15));
            default: begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return PAGES_ALL_ONES;
                    default: return PAGE_W'($urandom_range(65535));
                endcase
            end
        endcase
    endfunction

    // one book word, with random source gaps in front of it
    task automatic send_book(input logic [PAGE_W-1:0] pages, input bit last);
        @(negedge clk);
        while ($urandom_range(99) < book_idle_pct) begin
            book_bus.valid <= 1'b0;
            @(negedge clk);
        end
        book_bus.valid      <= 1'b1;
        book_bus.page_count <= pages;
        book_bus.last_book  <= last;
        do @(posedge clk); while (!book_bus.ready);
        shelve_book(pages, last);
        books_sent++;
    endtask

    // hold the source quiet until every partition has come back
    task automatic drain_partitions();
        @(negedge clk);
        book_bus.valid <= 1'b0;
        while (pending_partitions.size() != 0) @(posedge clk);
        // last result gone, let the sequencer get back to idle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_groups(input logic [GROUP_W-1:0] groups);
        drain_partitions();
        @(negedge clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.group_count <= groups;
        do @(posedge clk); while (!cfg_bus.ready);
        groups_cfg = groups;
        group_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_set(input int count, input t_page_mix mix);
        for (int i = 0; i < count; i++) begin
            send_book(random_pages(mix), i == count - 1);
        end
    endtask

    // group count left at its reset value of one
    task automatic test_reset_groups();
        send_book(16'd3, 1'b0);
        send_book(16'd5, 1'b0);
        send_book(16'd7, 1'b1);
        send_book(PAGES_ALL_ONES, 1'b1);
    endtask

    // field extremes, zero-page books and the too-few-books status
    task automatic test_directed_cases();
        write_groups(11'd2);
        // all-zero books: search stops at a bound of zero
        send_book(16'd0, 1'b0);
        send_book(16'd0, 1'b1);
        send_book(PAGES_ALL_ONES, 1'b0);
        send_book(16'd1, 1'b0);
        send_book(PAGES_ALL_ONES, 1'b1);
        // zero groups: never splittable
        write_groups(11'd0);
        send_book(16'd9, 1'b1);
        // more groups than books
        write_groups(11'd5);
        send_book(16'd1, 1'b0);
        send_book(16'd2, 1'b0);
        send_book(16'd3, 1'b1);
        write_groups(GROUPS_ALL_ONES);
        send_book(16'd4, 1'b1);
        write_groups(11'd3);
        for (int i = 1; i <= 5; i++) send_book(PAGE_W'(10 * i), i == 5);
        write_groups(11'd1);
        send_book(16'd0, 1'b1);
    endtask

    // books past the store limit are dropped; overflow wins over zero groups
    task automatic test_store_overflow();
        write_groups(11'd0);
        send_set(SHELF_DEPTH + 1, PAGES_NARROW);
        // next set must start clean
        write_groups(11'd1);
        send_set(3, PAGES_NARROW);
    endtask

    function automatic logic [GROUP_W-1:0] random_groups();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 11'd1024;
            2:       return GROUPS_ALL_ONES;
            3:       return GROUP_W'($urandom_range(1, 2047));
            default: return GROUP_W'($urandom_range(1, 6));
        endcase
    endfunction

    // random sets under one idling mix; group count changes between sets
    task automatic test_random_sets(input int idle_pct, input int stall_pct,
                                    input int book_budget);
        int first_book;
        int set_len;
        first_book       = books_sent;
        book_idle_pct    = idle_pct;
        result_stall_pct = stall_pct;
        write_groups(random_groups());
        while (books_sent - first_book < book_budget) begin
            if ($urandom_range(7) == 0) write_groups(random_groups());
            if ($urandom_range(7) == 0) set_len = $urandom_range(20, 64);
            else                        set_len = $urandom_range(1, 12);
            send_set(set_len, t_page_mix'($urandom_range(2)));
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        book_bus.valid      = 1'b0;
        book_bus.page_count = '0;
        book_bus.last_book  = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.group_count = '0;
        result_bus.ready    = 1'b0;
        book_idle_pct       = 0;
        result_stall_pct    = 0;
        errors              = 0;
        books_sent          = 0;
        sets_sent           = 0;
        results_seen        = 0;
        group_writes        = 0;
        cycle_count         = 0;
        status_tally        = '{0, 0, 0};
        shelf_count         = 0;
        shelf_total         = '0;
        shelf_overflow      = 1'b0;
        groups_cfg          = GROUP_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_groups();
        test_directed_cases();
        test_store_overflow();
        // idling mixes: none, source gaps, sink stalls, both
        test_random_sets(0, 0, 90);
        test_random_sets(87, 0, 90);
        test_random_sets(0, 87, 90);
        test_random_sets(38, 38, 90);
        drain_partitions();

        $display("covered %0d book words in %0d sets over %0d group count settings",
                 books_sent, sets_sent, group_writes);
        $display("partitions checked %0d: answered %0d, too few books %0d, overflowed %0d",
                 results_seen, status_tally[ST_OK], status_tally[ST_FEW],
                 status_tally[ST_OVF]);
        if (errors == 0 && pending_partitions.size() == 0) begin
            $display("PASS min_max_contiguous_partition_top");
        end else begin
            $display("FAIL min_max_contiguous_partition_top");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/mmcp_pkg.sv
src/mmcp_if.sv
src/mmcp_ram.sv
src/min_max_contiguous_partition_top.sv
tb/tb_min_max_contiguous_partition_top.sv
